/* hw/rtl/ata_pkg.sv */
package ata_pkg;

    // Quotient bits of the per-axis divider. Larger quotients saturate the result anyway.
    localparam int QUOT_BITS   = 17;
    localparam int LANE_DEPTH  = 3 + QUOT_BITS + 1;
    localparam int ISQRT_STEPS = 16;
    localparam int ATAN_LEN    = 24;
    localparam int PRE_SHIFT   = 8;
    localparam int CFG_W       = 14;

    typedef enum logic [2:0] {
        CFG_REF_MV   = 3'd0,
        CFG_MV_PER_G = 3'd1,
        CFG_ZERO_X   = 3'd2,
        CFG_ZERO_Y   = 3'd3,
        CFG_ZERO_Z   = 3'd4,
        CFG_OFF_X    = 3'd5,
        CFG_OFF_Y    = 3'd6,
        CFG_OFF_Z    = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
    } t_accel;

    typedef struct packed {
        t_accel             acc;
        logic signed [15:0] a;
        logic               err;
    } t_carry;

    typedef struct packed {
        t_accel            acc;
        logic signed [7:0] angle;
        logic              err;
    } t_result;

    // atan(2^-i) in degrees, Q16.
    function automatic logic [22:0] atan_q16(input int idx);
        logic [22:0] v;
        unique case (idx)
            0:  v = 23'd2949120;
            1:  v = 23'd1740967;
            2:  v = 23'd919879;
            3:  v = 23'd466945;
            4:  v = 23'd234379;
            5:  v = 23'd117304;
            6:  v = 23'd58666;
            7:  v = 23'd29335;
            8:  v = 23'd14668;
            9:  v = 23'd7334;
            10: v = 23'd3667;
            11: v = 23'd1833;
            12: v = 23'd917;
            13: v = 23'd458;
            14: v = 23'd229;
            15: v = 23'd115;
            16: v = 23'd57;
            17: v = 23'd29;
            18: v = 23'd14;
            19: v = 23'd7;
            20: v = 23'd4;
            21: v = 23'd2;
            22: v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/accel_tilt_angle_top.sv */
// Three-axis accelerometer front end with tilt angle. Each beat carries three 10-bit ADC
// codes and an axis selector; the result beat carries the three calibrated accelerations
// in signed milli-g (saturated to 16 bits) and the tilt angle of the selected axis in whole
// degrees, or axis_error with angle 0 for selector 3. One beat is accepted every cycle unless
// o_stall is high. Each beat passes through the 17-step divider in each axis lane, the
// 16-step square root and the CORDIC stages to a result register.
// A two-entry output buffer lets the pipeline keep running while a result waits.
// ADC_CODES is the full-scale code count and CORDIC_STEPS the rotation count (at most 24).
module accel_tilt_angle_top #(
    parameter int ADC_CODES    = 1024,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [9:0]                 i_raw_x,
    input  logic [9:0]                 i_raw_y,
    input  logic [9:0]                 i_raw_z,
    input  logic [1:0]                 i_axis,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [15:0]         o_accel_x_mg,
    output logic signed [15:0]         o_accel_y_mg,
    output logic signed [15:0]         o_accel_z_mg,
    output logic signed [7:0]          o_angle_deg,
    output logic                       o_axis_error,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_idx,
    input  logic [ata_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int AW    = $clog2(ADC_CODES + 1);
    localparam int DW    = AW + 10;
    localparam int CS    = (CORDIC_STEPS < ata_pkg::ATAN_LEN) ? CORDIC_STEPS : ata_pkg::ATAN_LEN;
    localparam int LD    = ata_pkg::LANE_DEPTH;
    localparam int DEPTH = LD + 1 + ata_pkg::ISQRT_STEPS + CS + 1;

    logic [12:0]        r_ref_mv;
    logic [9:0]         r_mv_per_g;
    logic [12:0]        r_zero_x, r_zero_y, r_zero_z;
    logic signed [13:0] r_off_x, r_off_y, r_off_z;

    logic [9:0]       w_sens;
    logic [DW-1:0]    w_div;
    logic             w_en;
    logic [DEPTH-1:0] r_vld;
    logic [1:0]       r_axis [LD];
    ata_pkg::t_accel  w_acc;
    ata_pkg::t_result w_res;
    ata_pkg::t_result r_out, r_skid;
    logic             r_out_vld, r_skid_vld;
    logic             w_out_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_mv   <= 13'd3300;
            r_mv_per_g <= 10'd330;
            r_zero_x   <= 13'd1650;
            r_zero_y   <= 13'd1650;
            r_zero_z   <= 13'd1650;
            r_off_x    <= '0;
            r_off_y    <= '0;
            r_off_z    <= '0;
        end else if (i_cfg_we) begin
            unique case (ata_pkg::t_cfg_idx'(i_cfg_idx))
                ata_pkg::CFG_REF_MV:   r_ref_mv   <= i_cfg_data[12:0];
                ata_pkg::CFG_MV_PER_G: r_mv_per_g <= i_cfg_data[9:0];
                ata_pkg::CFG_ZERO_X:   r_zero_x   <= i_cfg_data[12:0];
                ata_pkg::CFG_ZERO_Y:   r_zero_y   <= i_cfg_data[12:0];
                ata_pkg::CFG_ZERO_Z:   r_zero_z   <= i_cfg_data[12:0];
                ata_pkg::CFG_OFF_X:    r_off_x    <= $signed(i_cfg_data);
                ata_pkg::CFG_OFF_Y:    r_off_y    <= $signed(i_cfg_data);
                ata_pkg::CFG_OFF_Z:    r_off_z    <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // A sensitivity of zero is treated as one.
    assign w_sens = (r_mv_per_g == '0) ? 10'd1 : r_mv_per_g;
    assign w_div  = DW'(ADC_CODES) * DW'(w_sens);

    // The whole pipeline advances unless the output buffer is full.
    assign w_en    = !r_skid_vld;
    assign o_stall = r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_axis[0] <= i_axis;
            for (int k = 1; k < LD; k++) begin
                r_axis[k] <= r_axis[k-1];
            end
        end
    end

    ata_lane #(.ADC_CODES(ADC_CODES)) u_lane_x (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_raw      (i_raw_x),
        .i_ref_mv   (r_ref_mv),
        .i_zero_mv  (r_zero_x),
        .i_off_mg   (r_off_x),
        .i_div      (w_div),
        .o_accel_mg (w_acc.ax)
    );

    ata_lane #(.ADC_CODES(ADC_CODES)) u_lane_y (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_raw      (i_raw_y),
        .i_ref_mv   (r_ref_mv),
        .i_zero_mv  (r_zero_y),
        .i_off_mg   (r_off_y),
        .i_div      (w_div),
        .o_accel_mg (w_acc.ay)
    );

    ata_lane #(.ADC_CODES(ADC_CODES)) u_lane_z (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_raw      (i_raw_z),
        .i_ref_mv   (r_ref_mv),
        .i_zero_mv  (r_zero_z),
        .i_off_mg   (r_off_z),
        .i_div      (w_div),
        .o_accel_mg (w_acc.az)
    );

    ata_tilt #(.CORDIC_STEPS(CORDIC_STEPS)) u_tilt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_acc  (w_acc),
        .i_axis (r_axis[LD-1]),
        .o_res  (w_res)
    );

    assign w_out_take = r_out_vld && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_out_take) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || w_out_take) begin
            r_out_vld <= r_vld[DEPTH-1];
        end else if (r_vld[DEPTH-1]) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_out_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_vld || w_out_take) begin
            r_out <= w_res;
        end else begin
            r_skid <= w_res;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_accel_x_mg = r_out.acc.ax;
    assign o_accel_y_mg = r_out.acc.ay;
    assign o_accel_z_mg = r_out.acc.az;
    assign o_angle_deg  = r_out.angle;
    assign o_axis_error = r_out.err;

endmodule

/* hw/rtl/ata_lane.sv */
module ata_lane #(
    parameter int ADC_CODES = 1024,
    localparam int AW = $clog2(ADC_CODES + 1),
    localparam int DW = AW + 10
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [9:0]          i_raw,
    input  logic [12:0]         i_ref_mv,
    input  logic [12:0]         i_zero_mv,
    input  logic signed [13:0]  i_off_mg,
    input  logic [DW-1:0]       i_div,
    output logic signed [15:0]  o_accel_mg
);

    localparam int ZW = 13 + AW;
    localparam int PW = 23;
    localparam int NW = ((ZW > PW) ? ZW : PW) + 1;
    localparam int MW = NW + 10;
    localparam int QB = ata_pkg::QUOT_BITS;
    localparam int RW = DW + QB;
    localparam int CW = ((MW > RW) ? MW : RW) + 1;
    localparam int SW = QB + 2;
    localparam logic signed [SW-1:0] S_MAX = SW'(32767);
    localparam logic signed [SW-1:0] S_MIN = -SW'(32768);

    logic [PW-1:0]        w_prod;
    logic [ZW-1:0]        w_zs;
    logic signed [NW-1:0] w_n;
    logic signed [NW-1:0] r_n;
    logic [NW-1:0]        w_mag;
    logic [MW-1:0]        w_m;
    logic [MW-1:0]        r_m;
    logic                 r_neg1;
    logic [CW-1:0]        w_lim;

    logic [RW-1:0] r_rem [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic          r_sat [QB+1];
    logic          r_ng  [QB+1];

    logic [QB-1:0]        w_qm;
    logic signed [SW-1:0] w_qs;
    logic signed [SW-1:0] w_s;
    logic signed [15:0]   r_acc;

    assign w_prod = PW'(i_raw) * PW'(i_ref_mv);
    assign w_zs   = ZW'(i_zero_mv) * ZW'(ADC_CODES);
    assign w_n    = $signed(NW'(w_prod)) - $signed(NW'(w_zs));
    assign w_mag  = r_n[NW-1] ? NW'(-r_n) : NW'(r_n);
    assign w_m    = MW'(w_mag) * MW'(1000);
    assign w_lim  = CW'(i_div) << QB;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n      <= w_n;
            r_m      <= w_m;
            r_neg1   <= r_n[NW-1];
            r_rem[0] <= RW'(r_m);
            r_q[0]   <= '0;
            r_sat[0] <= (CW'(r_m) >= w_lim);
            r_ng[0]  <= r_neg1;
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar k = 0; k < QB; k++) begin : g_div
        localparam int SH = QB - 1 - k;
        logic [RW-1:0] w_sub;
        logic          w_ge;
        assign w_sub = RW'(i_div) << SH;
        assign w_ge  = (r_rem[k] >= w_sub);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= w_ge ? (r_rem[k] - w_sub) : r_rem[k];
                r_q[k+1]   <= r_q[k] | (QB'(w_ge) << SH);
                r_sat[k+1] <= r_sat[k];
                r_ng[k+1]  <= r_ng[k];
            end
        end
    end

    assign w_qm = r_sat[QB] ? '1 : r_q[QB];
    assign w_qs = r_ng[QB] ? -$signed(SW'(w_qm)) : $signed(SW'(w_qm));
    assign w_s  = w_qs + SW'(i_off_mg);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_s > S_MAX) begin
                r_acc <= 16'sh7FFF;
            end else if (w_s < S_MIN) begin
                r_acc <= -16'sh8000;
            end else begin
                r_acc <= 16'(w_s);
            end
        end
    end

    assign o_accel_mg = r_acc;

endmodule

/* hw/rtl/ata_tilt.sv */
module ata_tilt #(
    parameter int CORDIC_STEPS = 16,
    localparam int CS = (CORDIC_STEPS < ata_pkg::ATAN_LEN) ? CORDIC_STEPS : ata_pkg::ATAN_LEN
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  ata_pkg::t_accel  i_acc,
    input  logic [1:0]       i_axis,
    output ata_pkg::t_result o_res
);

    localparam int IS = ata_pkg::ISQRT_STEPS;
    localparam int XW = 27;
    localparam int ZW = 26;

    logic signed [15:0] w_a, w_b, w_c;
    logic               w_err;
    logic signed [31:0] w_sb, w_sc;
    logic [31:0]        w_sum;
    ata_pkg::t_carry    w_car;

    logic [31:0]     r_v  [IS+1];
    logic [31:0]     r_r  [IS+1];
    ata_pkg::t_carry r_cq [IS+1];

    logic signed [XW-1:0] w_x [CS+1];
    logic signed [XW-1:0] w_y [CS+1];
    logic signed [ZW-1:0] w_z [CS+1];
    ata_pkg::t_carry      w_cc [CS+1];
    logic                 w_rz [CS+1];

    logic signed [XW-1:0] r_x [CS];
    logic signed [XW-1:0] r_y [CS];
    logic signed [ZW-1:0] r_z [CS];
    ata_pkg::t_carry      r_cc [CS];
    logic                 r_rz [CS];

    logic [ZW-1:0]     w_zmag;
    logic [ZW-17:0]    w_dmag;
    logic [7:0]        w_dclp;
    logic signed [7:0] w_deg;
    ata_pkg::t_result  r_res;

    always_comb begin
        w_err = 1'b0;
        unique case (ata_pkg::t_axis'(i_axis))
            ata_pkg::AXIS_X: begin
                w_a = i_acc.ax; w_b = i_acc.ay; w_c = i_acc.az;
            end
            ata_pkg::AXIS_Y: begin
                w_a = i_acc.ay; w_b = i_acc.ax; w_c = i_acc.az;
            end
            ata_pkg::AXIS_Z: begin
                w_a = i_acc.az; w_b = i_acc.ay; w_c = i_acc.ax;
            end
            default: begin
                w_a = i_acc.ax; w_b = i_acc.ay; w_c = i_acc.az;
                w_err = 1'b1;
            end
        endcase
    end

    assign w_sb  = 32'(w_b) * 32'(w_b);
    assign w_sc  = 32'(w_c) * 32'(w_c);
    assign w_sum = $unsigned(w_sb) + $unsigned(w_sc);
    assign w_car = '{acc: i_acc, a: w_a, err: w_err};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0]  <= w_sum;
            r_r[0]  <= '0;
            r_cq[0] <= w_car;
        end
    end

    // Integer square root, two radicand bits per stage.
    for (genvar k = 0; k < IS; k++) begin : g_sqrt
        localparam logic [31:0] BIT = 32'd1 << (30 - 2 * k);
        logic [32:0] w_t;
        logic        w_ge;
        assign w_t  = {1'b0, r_r[k]} + {1'b0, BIT};
        assign w_ge = ({1'b0, r_v[k]} >= w_t);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[k+1]  <= w_ge ? (r_v[k] - w_t[31:0]) : r_v[k];
                r_r[k+1]  <= w_ge ? ((r_r[k] >> 1) + BIT) : (r_r[k] >> 1);
                r_cq[k+1] <= r_cq[k];
            end
        end
    end

    assign w_x[0]  = XW'(r_r[IS][15:0]) << ata_pkg::PRE_SHIFT;
    assign w_y[0]  = XW'(r_cq[IS].a) <<< ata_pkg::PRE_SHIFT;
    assign w_z[0]  = '0;
    assign w_cc[0] = r_cq[IS];
    assign w_rz[0] = (r_r[IS] == '0);

    // Vectoring CORDIC: rotate toward the x axis, accumulating the angle.
    for (genvar j = 0; j < CS; j++) begin : g_cordic
        localparam logic signed [ZW-1:0] AT = ZW'(ata_pkg::atan_q16(j));
        logic signed [XW-1:0] w_xs, w_ys;
        logic                 w_pos;
        assign w_xs  = w_x[j] >>> j;
        assign w_ys  = w_y[j] >>> j;
        assign w_pos = !w_y[j][XW-1];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[j]  <= w_pos ? (w_x[j] + w_ys) : (w_x[j] - w_ys);
                r_y[j]  <= w_pos ? (w_y[j] - w_xs) : (w_y[j] + w_xs);
                r_z[j]  <= w_pos ? (w_z[j] + AT) : (w_z[j] - AT);
                r_cc[j] <= w_cc[j];
                r_rz[j] <= w_rz[j];
            end
        end
        assign w_x[j+1]  = r_x[j];
        assign w_y[j+1]  = r_y[j];
        assign w_z[j+1]  = r_z[j];
        assign w_cc[j+1] = r_cc[j];
        assign w_rz[j+1] = r_rz[j];
    end

    // Truncate toward zero by working on the magnitude.
    assign w_zmag = w_z[CS][ZW-1] ? ZW'(-w_z[CS]) : ZW'(w_z[CS]);
    assign w_dmag = w_zmag[ZW-1:16];
    assign w_dclp = (w_dmag > (ZW-16)'(90)) ? 8'd90 : 8'(w_dmag);
    assign w_deg  = w_z[CS][ZW-1] ? -$signed(w_dclp) : $signed(w_dclp);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.acc <= w_cc[CS].acc;
            r_res.err <= w_cc[CS].err;
            if (w_cc[CS].err) begin
                r_res.angle <= 8'sd0;
            end else if (w_rz[CS]) begin
                if (w_cc[CS].a > 16'sd0) begin
                    r_res.angle <= 8'sd90;
                end else if (w_cc[CS].a < 16'sd0) begin
                    r_res.angle <= -8'sd90;
                end else begin
                    r_res.angle <= 8'sd0;
                end
            end else begin
                r_res.angle <= w_deg;
            end
        end
    end

    assign o_res = r_res;

endmodule
